// ===== design/cir_pkg.sv =====
// Shared types, codes and constants for the CRC-checked image receiver.
package cir_pkg;

  localparam int unsigned MAX_BYTES_DEF = 2097152;
  localparam int LEN_W = 22;
  localparam int CNT_W = 22;
  localparam int GEN_W = 16;

  localparam logic [31:0] CRC_POLY = 32'h04c1_1db7;
  localparam logic [31:0] CRC_SEED = 32'hffff_ffff;

  localparam logic [7:0] JPEG_PREFIX = 8'hff;
  localparam logic [7:0] JPEG_SOI    = 8'hd8;
  localparam logic [7:0] JPEG_EOI    = 8'hd9;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_ABORT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SIZE     = 3'd1,
    ST_CRC      = 3'd2,
    ST_NOT_JPEG = 3'd3,
    ST_ABORT    = 3'd4
  } status_t;

  // Transfer state, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_RECEIVING = 4'b0010,
    MODE_READY     = 4'b0100,
    MODE_ERROR     = 4'b1000
  } mode_t;

  localparam logic [1:0] MODE_CODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_CODE_RECEIVING = 2'd1;
  localparam logic [1:0] MODE_CODE_READY     = 2'd2;
  localparam logic [1:0] MODE_CODE_ERROR     = 2'd3;

  typedef struct packed {
    status_t            status;
    logic [1:0]         mode;
    logic [CNT_W-1:0]   byte_count;
    logic               image_ready;
    logic [GEN_W-1:0]   generation;
  } result_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      MODE_IDLE:      c = MODE_CODE_IDLE;
      MODE_RECEIVING: c = MODE_CODE_RECEIVING;
      MODE_READY:     c = MODE_CODE_READY;
      MODE_ERROR:     c = MODE_CODE_ERROR;
      default:        c = MODE_CODE_ERROR;
    endcase
    return c;
  endfunction

endpackage

// ===== design/crc_checked_image_receiver.sv =====
// Top level of the CRC-checked image receiver: input register, control core, result register.
//
// Usage:
//   Input stream (s_axis_*): one transfer per item. tuser carries the item kind
//   (0 start, 1 data byte, 2 end, 3 abort); tdata carries the value (length for
//   start, byte in bits 7:0 for data, peer failure flag for end).
//   Output stream (m_axis_*): exactly one result per input item, in order,
//   holding status, mode, byte count, image-ready flag and generation counter.
// Path: the item sits in the input register, then the state update loads the result
//   register, which raises m_axis_tvalid; a stall can hold the item between the two.
// Throughput: one item per cycle while m_axis_tready stays high. The whole step
//   (byte-wide CRC update, marker compare, length checks) is one combinational pass
//   from the input register to the result register.
// Stall: when m_axis_tready is low with a result held, the input register
//   keeps its item and s_axis_tready drops once it is full; nothing is lost.
// Reset (rst, synchronous, active high): both registers empty, transfer idle,
//   CRC seeded with all ones, counters, markers, image flag and generation zero.
module crc_checked_image_receiver import cir_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [21:0] value, [23:22] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [2:0] status, [4:3] mode, [26:5] byte_count,
                                     // [27] image_ready, [43:28] generation, [47:44] zero
);

  logic             item_valid;
  func_t            item_func;
  logic [LEN_W-1:0] item_value;
  logic             advance;
  logic             in_xfer;
  result_t          res;
  result_t          out_res;
  logic             out_valid;

  // Advance the held item when the result register is free or being drained.
  assign advance       = item_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_xfer) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Hold the payload until the core takes it.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_func  <= func_t'(s_axis_tuser);
      item_value <= s_axis_tdata[LEN_W-1:0];
    end
  end

  cir_ctrl #(
    .MAX_BYTES (MAX_BYTES)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .func  (item_func),
    .value (item_value),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_res.generation, out_res.image_ready,
                          out_res.byte_count, out_res.mode, out_res.status};

endmodule

// ===== design/cir_crc8.sv =====
// One-byte CRC-32/MPEG-2 update, MSB first, unrolled over eight bit steps.
module cir_crc8 import cir_pkg::*; (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {data, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    crc_out = c;
  end

endmodule

// ===== design/cir_ctrl.sv =====
// Transfer state, CRC and marker tracking, and the per-item result logic.
module cir_ctrl import cir_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  func_t            func,
  input  logic [LEN_W-1:0] value,
  output result_t          res
);

  localparam logic [LEN_W:0] MaxLen = (LEN_W+1)'(MAX_BYTES);

  mode_t            mode, mode_next;
  logic [LEN_W-1:0] exp_len, exp_len_next;
  logic [CNT_W-1:0] count, count_next;
  logic [31:0]      crc, crc_next;
  logic [31:0]      trailer, trailer_next;
  logic [7:0]       prev_byte, prev_byte_next;
  logic [1:0]       markers, markers_next;
  logic [GEN_W-1:0] generation, generation_next;
  logic             image_flag, image_flag_next;
  status_t          status;

  logic [7:0]       data_byte;
  logic [31:0]      crc_upd;
  logic [CNT_W:0]   count_inc;
  logic [31:0]      trailer_shifted;
  logic             len_bad;
  logic             in_payload;

  assign data_byte       = value[7:0];
  assign count_inc       = {1'b0, count} + 1'b1;
  assign in_payload      = (count_inc + (CNT_W+1)'(4)) <= {1'b0, exp_len};
  assign trailer_shifted = {trailer[23:0], data_byte};
  assign len_bad         = (value <= LEN_W'(4)) || ({1'b0, value} > MaxLen) ||
                           (value[1:0] != 2'b00);

  cir_crc8 u_crc8 (
    .crc_in  (crc),
    .data    (data_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    mode_next       = mode;
    exp_len_next    = exp_len;
    count_next      = count;
    crc_next        = crc;
    trailer_next    = trailer;
    prev_byte_next  = prev_byte;
    markers_next    = markers;
    generation_next = generation;
    image_flag_next = image_flag;
    status          = ST_OK;
    case (func)
      FUNC_START: begin
        if (len_bad) begin
          status    = ST_SIZE;
          mode_next = MODE_ERROR;
        end else begin
          exp_len_next   = value;
          count_next     = '0;
          crc_next       = CRC_SEED;
          trailer_next   = '0;
          prev_byte_next = '0;
          markers_next   = '0;
          mode_next      = MODE_RECEIVING;
        end
      end
      FUNC_DATA: begin
        if (mode != MODE_RECEIVING || count >= exp_len) begin
          status    = ST_SIZE;
          mode_next = MODE_ERROR;
        end else if (in_payload) begin
          crc_next       = crc_upd;
          prev_byte_next = data_byte;
          if (prev_byte == JPEG_PREFIX && data_byte == JPEG_SOI) markers_next[0] = 1'b1;
          if (prev_byte == JPEG_PREFIX && data_byte == JPEG_EOI) markers_next[1] = 1'b1;
          count_next = count_inc[CNT_W-1:0];
        end else begin
          trailer_next = trailer_shifted;
          // Final byte: expected CRC must match; a mismatch leaves it uncounted.
          if (count_inc[CNT_W-1:0] == exp_len && trailer_shifted != crc) begin
            status    = ST_CRC;
            mode_next = MODE_ERROR;
          end else begin
            count_next = count_inc[CNT_W-1:0];
          end
        end
      end
      FUNC_END: begin
        if (value != '0 || count != exp_len) begin
          status    = ST_SIZE;
          mode_next = MODE_ERROR;
        end else if (mode != MODE_RECEIVING || markers != 2'b11) begin
          status    = ST_NOT_JPEG;
          mode_next = MODE_ERROR;
        end else begin
          image_flag_next = 1'b1;
          generation_next = generation + 1'b1;
          mode_next       = MODE_READY;
        end
      end
      FUNC_ABORT: begin
        status    = ST_ABORT;
        mode_next = MODE_ERROR;
      end
      default: begin
        status    = ST_ABORT;
        mode_next = MODE_ERROR;
      end
    endcase
  end

  always_comb begin
    res.status      = status;
    res.mode        = mode_code(mode_next);
    res.byte_count  = count_next;
    res.image_ready = image_flag_next;
    res.generation  = generation_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      exp_len    <= '0;
      count      <= '0;
      crc        <= CRC_SEED;
      trailer    <= '0;
      prev_byte  <= '0;
      markers    <= '0;
      generation <= '0;
      image_flag <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      exp_len    <= exp_len_next;
      count      <= count_next;
      crc        <= crc_next;
      trailer    <= trailer_next;
      prev_byte  <= prev_byte_next;
      markers    <= markers_next;
      generation <= generation_next;
      image_flag <= image_flag_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_RECEIVING) |-> (count <= exp_len))
    else $error("byte count ran past announced length");

  a_ready_has_image: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_READY) |-> image_flag)
    else $error("ready state without committed image");

  a_image_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(image_flag))
    else $error("image flag cleared outside reset");

  a_commit_gen: assert property (@(posedge clk) disable iff (rst)
    (step && func == FUNC_END && status == ST_OK) |=>
      (generation == $past(generation) + 1'b1))
    else $error("commit did not advance generation");

endmodule
